// File: rtl/core/swn_pkg.sv
`timescale 1ns / 1ps

package swn_pkg;

  localparam logic [7:0] CH_QUOTE   = 8'h27;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_DELTA = 8'h20;
  localparam logic [7:0] CH_NONE    = 8'h00;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] ch;
    logic       line_end;
  } char_beat_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       is_end;
    logic       last;
  } norm_beat_t;

  // Up to three results per character, always in the order space, char, end.
  typedef struct packed {
    logic       emit_end;
    logic       emit_char;
    logic       emit_space;
    logic [7:0] chr;
  } cmd_t;

endpackage

// File: rtl/core/swn_front.sv
`timescale 1ns / 1ps

module swn_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                char_valid,
  output logic                char_ready,
  input  swn_pkg::char_beat_t char_beat,
  input  logic                q_ready,
  output logic                q_push,
  output swn_pkg::cmd_t       q_cmd
);
  import swn_pkg::*;

  logic in_quote, drop_whitespace, space_pending;
  logic in_quote_next, drop_whitespace_next, space_pending_next;
  logic ws, mark, accept;
  logic [7:0] c;

  assign c      = char_beat.ch;
  assign ws     = (c == CH_SPACE) || (c == CH_NEWLINE);
  assign mark   = (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_COMMA);
  assign accept = char_valid && char_ready;

  assign char_ready = q_ready;

  always_comb begin
    in_quote_next        = in_quote;
    drop_whitespace_next = drop_whitespace;
    space_pending_next   = space_pending;
    q_cmd                = '0;
    q_cmd.chr            = c;
    if (ws) begin
      if (drop_whitespace) begin
        q_cmd.emit_char = 1'b0;
      end else if (in_quote) begin
        q_cmd.emit_char = 1'b1;
      end else begin
        space_pending_next = 1'b1;
      end
    end else if (mark) begin
      space_pending_next   = 1'b0;
      drop_whitespace_next = 1'b1;
      q_cmd.emit_char      = 1'b1;
    end else begin
      q_cmd.emit_space     = space_pending;
      space_pending_next   = 1'b0;
      drop_whitespace_next = 1'b0;
      q_cmd.emit_char      = 1'b1;
      if (c == CH_QUOTE) begin
        in_quote_next = !in_quote;
      end else if (!in_quote && c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
        q_cmd.chr = c - CASE_DELTA;
      end
    end
    if (char_beat.line_end) begin
      q_cmd.emit_space     = q_cmd.emit_space | space_pending_next;
      q_cmd.emit_end       = 1'b1;
      in_quote_next        = 1'b0;
      drop_whitespace_next = 1'b0;
      space_pending_next   = 1'b0;
    end
  end

  assign q_push = accept && (q_cmd.emit_space || q_cmd.emit_char || q_cmd.emit_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_quote        <= 1'b0;
      drop_whitespace <= 1'b0;
      space_pending   <= 1'b0;
    end else if (accept) begin
      in_quote        <= in_quote_next;
      drop_whitespace <= drop_whitespace_next;
      space_pending   <= space_pending_next;
    end
  end

endmodule

// File: rtl/core/swn_queue.sv
`timescale 1ns / 1ps

module swn_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  swn_pkg::cmd_t push_cmd,
  output logic          not_full,
  input  logic          pop,
  output logic          head_valid,
  output swn_pkg::cmd_t head_cmd
);
  import swn_pkg::*;

  cmd_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_CW-1:0] count;

  assign not_full   = (count != QUEUE_CW'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> not_full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
      count <= QUEUE_CW'(QUEUE_DEPTH))
    else $error("queue count out of range");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
      (wr_ptr - rd_ptr) == count[QUEUE_AW-1:0])
    else $error("queue pointers disagree with count");
`endif

endmodule

// File: rtl/core/swn_back.sv
`timescale 1ns / 1ps

module swn_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  swn_pkg::cmd_t       q_cmd,
  output logic                q_pop,
  output logic                norm_valid,
  input  logic                norm_ready,
  output swn_pkg::norm_beat_t norm_beat
);
  import swn_pkg::*;

  // done bits: {end, char, space} already sent from the head command
  logic [2:0] done, rem, sel, rest;
  logic       load, is_last;
  norm_beat_t beat_next;

  assign rem  = {q_cmd.emit_end, q_cmd.emit_char, q_cmd.emit_space} & ~done;
  assign sel  = rem & (~rem + 3'd1);
  assign rest = rem & ~sel;
  assign is_last = (rest == '0);
  assign load  = q_valid && (!norm_valid || norm_ready);
  assign q_pop = load && is_last;

  always_comb begin
    beat_next.last = is_last;
    if (sel[0]) begin
      beat_next.out_char = CH_SPACE;
      beat_next.is_end   = 1'b0;
    end else if (sel[1]) begin
      beat_next.out_char = q_cmd.chr;
      beat_next.is_end   = 1'b0;
    end else begin
      beat_next.out_char = CH_NONE;
      beat_next.is_end   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      norm_valid <= 1'b0;
      done       <= '0;
    end else if (load) begin
      norm_valid <= 1'b1;
      done       <= is_last ? 3'b000 : (done | sel);
    end else if (norm_ready) begin
      norm_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      norm_beat <= beat_next;
    end
  end

`ifndef SYNTHESIS
  a_head_has_work: assert property (@(posedge clk) disable iff (rst)
      q_valid |-> (rem != '0))
    else $error("head command with nothing left to send");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
      !q_valid |-> (done == '0))
    else $error("progress bits set with empty queue");
  a_last_pops: assert property (@(posedge clk) disable iff (rst)
      (load && is_last) |=> (done == '0))
    else $error("progress not cleared after final result");
  a_one_select: assert property (@(posedge clk) disable iff (rst)
      q_valid |-> $onehot(sel))
    else $error("result selection not one-hot");
`endif

endmodule

// File: rtl/core/sql_whitespace_normalizer.sv
`timescale 1ns / 1ps
// Channel   Beat type    Handshake                Content
// char      char_beat_t  char_valid / char_ready  raw byte and line_end flag
// norm      norm_beat_t  norm_valid / norm_ready  out_char, is_end, last
//
// One character is accepted per cycle while the four-entry command queue has room.
// Each character yields zero to three results; the back end sends one result per cycle
// while the output is not stalled, from its single output register.
// An accepted character's command is written into the queue, then loaded into the output register.
// Synchronous reset clears the quote, drop and pending-space flags and empties the queue.
// A stalled output fills the queue; input stalls only once the queue is full.

module sql_whitespace_normalizer (
  input  logic                clk,
  input  logic                rst,
  input  logic                char_valid,
  output logic                char_ready,
  input  swn_pkg::char_beat_t char_beat,
  output logic                norm_valid,
  input  logic                norm_ready,
  output swn_pkg::norm_beat_t norm_beat
);
  import swn_pkg::*;

  logic push, pop, not_full, head_valid;
  cmd_t push_cmd, head_cmd;

  swn_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_beat  (char_beat),
    .q_ready    (not_full),
    .q_push     (push),
    .q_cmd      (push_cmd)
  );

  swn_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .not_full   (not_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  swn_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (head_valid),
    .q_cmd      (head_cmd),
    .q_pop      (pop),
    .norm_valid (norm_valid),
    .norm_ready (norm_ready),
    .norm_beat  (norm_beat)
  );

endmodule
